@@ src/gsp_pkg.sv @@
// Package for the gas sensor ppm converter: constants, codes and the exp2 table.
`default_nettype none
package gsp_pkg;
   localparam int LOAD_W  = 20;
   localparam int CAR_W   = 16;
   localparam int COEFA_W = 24;
   localparam int COEFB_W = 16;
   localparam int RAW_W   = 12;
   localparam int CSR_W   = 24;
   localparam int CSR_IDX_W = 2;
   localparam int DEF_ADC_BITS = 12;
   localparam int DEF_CAL_SAMPLES = 100;

   localparam logic [CSR_IDX_W-1:0] REG_LOAD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEFA = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEFB = 2'd3;

   localparam logic [1:0] ST_CAL   = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_MEAS  = 2'd2;
   localparam logic [1:0] ST_ZERO  = 2'd3;

   // shared divider request: 64-bit dividend, 32-bit divisor
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quot;
   } div_rsp_type;

   function automatic logic [31:0] exp2_tab(input logic [3:0] k);
      logic [31:0] v;
      case (k)
         4'd0: v = 32'd1518500250;
         4'd1: v = 32'd1276901417;
         4'd2: v = 32'd1170923762;
         4'd3: v = 32'd1121280436;
         4'd4: v = 32'd1097253708;
         4'd5: v = 32'd1085434106;
         4'd6: v = 32'd1079572136;
         4'd7: v = 32'd1076653033;
         4'd8: v = 32'd1075196443;
         4'd9: v = 32'd1074468888;
         4'd10: v = 32'd1074105294;
         4'd11: v = 32'd1073923544;
         4'd12: v = 32'd1073832680;
         4'd13: v = 32'd1073787251;
         4'd14: v = 32'd1073764537;
         default: v = 32'd1073753181;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

@@ src/gsp_divider.sv @@
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
`default_nettype none
module gsp_divider (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gsp_pkg::div_req_type req,
   output gsp_pkg::div_rsp_type      rsp
);
   import gsp_pkg::*;
   logic [63:0] quot_ff, quot_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;
   logic [33:0] diff;

   always_comb begin
      quot_in = quot_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[31:0], quot_ff[63]};
      diff = {1'b0, trial} - {2'b00, den_ff};
      if (req.start) begin
         quot_in = req.num; rem_in = '0; den_in = req.den;
         cnt_in = 7'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_in = diff[32:0];
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in; rem_ff <= rem_in; den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_no_busy_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("busy and done together");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff) else $error("busy dropped without done");
endmodule
`default_nettype wire

@@ src/gas_sensor_ppm_converter.sv @@
// Top level: sequencer around a shared divider and a shared multiplier.
// The divider gives one quotient bit per cycle, 64 steps per division. Each sample is
// handled after its input transfer: one division for Rs for a calibration sample, Rs
// then the base resistance division for the sample that ends calibration, and Rs and
// ratio divisions, then 16 log2 squaring steps and 16 exp2 multiply steps on one 33x33
// multiplier, when measuring. A zero sample goes straight to the output state. The result
// sits in an output register; req_tready is low while a sample is in work or its result
// waits, and rises the cycle after the result transfer.
`default_nettype none
module gas_sensor_ppm_converter #(
   parameter int ADC_BITS    = gsp_pkg::DEF_ADC_BITS,
   parameter int CAL_SAMPLES = gsp_pkg::DEF_CAL_SAMPLES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [15:0]                     req_tdata,   // raw_sample[11:0]
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [95:0]                          rsp_tdata,   // sensor_resistance, resistance_ratio, gas_ppm, pad
   output logic [1:0]                           rsp_tuser,   // status
   input  wire logic                            csr_we,
   input  wire logic [gsp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gsp_pkg::CSR_W-1:0]       csr_wdata
);
   import gsp_pkg::*;

   localparam logic [16:0] FS = 17'((1 << ADC_BITS) - 1);
   localparam logic [6:0]  CAL_N = 7'(CAL_SAMPLES);

   typedef enum logic [3:0] {
      S_IDLE, S_RS, S_RS_W, S_CAL, S_CAL_W, S_RAT, S_RAT_W,
      S_NORM, S_LOG, S_MUL, S_EXP, S_PPM, S_OUT
   } state_type;

   state_type state_ff;
   logic [LOAD_W-1:0]  load_ff;
   logic [CAR_W-1:0]   car_ff;
   logic [COEFA_W-1:0] coefa_ff;
   logic [COEFB_W-1:0] coefb_ff;
   logic [6:0]  count_ff;
   logic [39:0] sum_ff;
   logic [31:0] base_ff;
   logic        cal_ff;
   logic [11:0] raw_ff;
   logic [31:0] rs_ff;
   logic [23:0] ratio_ff;
   logic [31:0] ppm_ff;
   logic [1:0]  stat_ff;
   logic        ovalid_ff;
   logic [24:0] m_ff;
   logic [4:0]  p_ff;
   logic [15:0] frac_ff;
   logic [4:0]  step_ff;
   logic signed [36:0] e_ff;
   logic [31:0] acc_ff;
   logic [63:0] prod_ff;

   div_req_type dreq;
   div_rsp_type drsp;
   gsp_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // shared multiplier, operands sign extended only for the log times exponent step
   logic [31:0] mul_a, mul_b;
   logic        mul_sgn;
   logic signed [65:0] mul_w;
   logic [63:0] mul_p;
   assign mul_w = $signed({mul_sgn & mul_a[31], mul_a}) * $signed({mul_sgn & mul_b[31], mul_b});
   assign mul_p = mul_w[63:0];

   logic [11:0] raw_in_w;
   logic [4:0]  msb;
   logic [31:0] exp_f;
   logic signed [20:0] n_w;
   logic signed [21:0] sh;
   logic [63:0] fin;

   assign raw_in_w = req_tdata[11:0];

   always_comb begin
      msb = 5'd0;
      for (int i = 0; i < 24; i++)
         if (ratio_ff[i]) msb = 5'(i);
   end

   always_comb begin
      mul_a = '0; mul_b = '0; mul_sgn = 1'b0;
      unique case (state_ff)
         S_RS:  begin mul_a = 32'(load_ff); mul_b = 32'(FS - 17'(raw_ff)); end
         S_LOG: begin mul_a = 32'(m_ff); mul_b = 32'(m_ff); end
         S_MUL: begin
            mul_a = 32'($unsigned(32'(signed'({1'b0, p_ff}) - 32'sd16) * 32'sd65536
                    + 32'(frac_ff)));
            mul_b = 32'(signed'(coefb_ff));
            mul_sgn = 1'b1;
         end
         S_EXP: begin mul_a = acc_ff; mul_b = exp2_tab(4'(step_ff)); end
         S_PPM: begin mul_a = 32'(coefa_ff); mul_b = acc_ff; end
         default: ;
      endcase
   end

   assign n_w = 21'(e_ff >>> 16);
   assign exp_f = 32'(e_ff[15:0]);
   assign sh = 22'(n_w) - 22'sd30;

   always_comb begin
      fin = '1;
      if (prod_ff == 64'd0) fin = '0;
      else if (!sh[21]) begin
         if (sh >= 22'sd32 || prod_ff > (64'hFFFF_FFFF >> sh[4:0])) fin = '1;
         else fin = prod_ff << sh[4:0];
      end else if (-sh >= 22'sd64) fin = '0;
      else begin
         fin = prod_ff >> 6'(-sh);
         if (fin > 64'hFFFF_FFFF) fin = 64'hFFFF_FFFF;
      end
   end

   always_comb begin
      dreq = '0;
      dreq.start = (state_ff == S_RS && raw_ff <= 12'(FS))
                || (state_ff == S_CAL) || (state_ff == S_RAT);
      if (state_ff == S_RS) begin
         dreq.num = mul_p; dreq.den = 32'(raw_ff);
      end else if (state_ff == S_CAL) begin
         dreq.num = {16'd0, sum_ff, 8'd0};
         dreq.den = 32'(CAL_N) * 32'(car_ff);
      end else begin
         dreq.num = {16'd0, rs_ff, 16'd0}; dreq.den = base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ovalid_ff <= 1'b0;
         load_ff <= 20'd10000; car_ff <= 16'd2534; coefa_ff <= 24'd256000;
         coefb_ff <= 16'hDCCD;
         count_ff <= '0; sum_ff <= '0; base_ff <= '0; cal_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_LOAD:  load_ff <= csr_wdata[LOAD_W-1:0];
               REG_CAR:   car_ff <= csr_wdata[CAR_W-1:0];
               REG_COEFA: coefa_ff <= csr_wdata[COEFA_W-1:0];
               REG_COEFB: coefb_ff <= csr_wdata[COEFB_W-1:0];
               default: ;
            endcase
         end
         if (ovalid_ff && rsp_tready) ovalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               raw_ff <= raw_in_w;
               ratio_ff <= '0; ppm_ff <= '0; rs_ff <= '0;
               if (raw_in_w == 12'd0) begin
                  stat_ff <= ST_ZERO; state_ff <= S_OUT;
               end else state_ff <= S_RS;
            end
            S_RS: if (raw_ff > 12'(FS)) begin
               rs_ff <= '0; state_ff <= cal_ff ? S_RAT : S_CAL;
               if (!cal_ff) begin
                  count_ff <= count_ff + 7'd1;
                  stat_ff <= ST_CAL;
                  if (count_ff + 7'd1 < CAL_N) state_ff <= S_OUT;
               end
            end else state_ff <= S_RS_W;
            S_RS_W: if (drsp.done) begin
               rs_ff <= (drsp.quot > 64'hFFFF_FFFF) ? '1 : drsp.quot[31:0];
               if (!cal_ff) begin
                  sum_ff <= sum_ff + 40'((drsp.quot > 64'hFFFF_FFFF) ?
                            64'hFFFF_FFFF : drsp.quot);
                  count_ff <= count_ff + 7'd1;
                  stat_ff <= ST_CAL;
                  state_ff <= (count_ff + 7'd1 >= CAL_N) ? S_CAL : S_OUT;
               end else state_ff <= S_RAT;
            end
            S_CAL: state_ff <= S_CAL_W;
            S_CAL_W: if (drsp.done) begin
               base_ff <= (car_ff == 16'd0 || drsp.quot > 64'hFFFF_FFFF) ? '1
                          : drsp.quot[31:0];
               cal_ff <= 1'b1; stat_ff <= ST_DONE; state_ff <= S_OUT;
            end
            S_RAT: state_ff <= S_RAT_W;
            S_RAT_W: if (drsp.done) begin
               stat_ff <= ST_MEAS;
               ratio_ff <= (base_ff == 0 || drsp.quot > 64'hFF_FFFF) ? '1
                           : drsp.quot[23:0];
               state_ff <= S_NORM;
            end
            S_NORM: begin
               if (ratio_ff == 24'd0) begin
                  if (!coefb_ff[15] && coefb_ff != 0) ppm_ff <= '0;
                  else if (coefb_ff == 0) ppm_ff <= 32'(coefa_ff);
                  else ppm_ff <= '1;
                  state_ff <= S_OUT;
               end else begin
                  p_ff <= msb;
                  m_ff <= 25'(ratio_ff << (5'd23 - msb));
                  frac_ff <= '0; step_ff <= '0; state_ff <= S_LOG;
               end
            end
            S_LOG: begin
               frac_ff <= {frac_ff[14:0], mul_p[47]};
               m_ff <= mul_p[47] ? 25'(mul_p >> 24) : 25'(mul_p >> 23);
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'd15) state_ff <= S_MUL;
            end
            S_MUL: begin
               e_ff <= 37'(signed'(mul_p) >>> 12);
               acc_ff <= 32'd1 << 30; step_ff <= '0; state_ff <= S_EXP;
            end
            S_EXP: begin
               if (exp_f[5'd15 - 5'(step_ff[3:0])])
                  acc_ff <= 32'(mul_p >> 30);
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'd15) state_ff <= S_PPM;
            end
            S_PPM: begin prod_ff <= mul_p; state_ff <= S_OUT; step_ff <= 5'd31; end
            S_OUT: begin
               if (step_ff == 5'd31 && stat_ff == ST_MEAS && ratio_ff != 0)
                  ppm_ff <= fin[31:0];
               step_ff <= '0;
               if (!ovalid_ff || rsp_tready) begin
                  ovalid_ff <= 1'b1; state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   logic [31:0] ppm_out;
   assign ppm_out = ppm_ff;
   assign req_tready = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser = stat_ff;
   assign rsp_tdata = {8'd0, ppm_out, ratio_ff, rs_ff};

   a_zero_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_ZERO |-> rsp_tdata[31:0] == 32'd0)
      else $error("zero sample with resistance");
   a_cal_no_ppm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_CAL |-> rsp_tdata[87:32] == '0)
      else $error("ppm during calibration");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready with pending result");
endmodule
`default_nettype wire

@@ dv/gas_sensor_ppm_checker.sv @@
// Checker for the gas sensor ppm converter: predicts each result and compares transfers.
`default_nettype none
module gas_sensor_ppm_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic                          req_tready,
   input  wire logic [15:0]                   req_tdata,
   input  wire logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic [95:0]                   rsp_tdata,
   input  wire logic [1:0]                    rsp_tuser,
   input  wire logic                          csr_we,
   input  wire logic [gsp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gsp_pkg::CSR_W-1:0]     csr_wdata,
   output int                                 errors,
   output int                                 pending
);
   import gsp_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] rs;
      logic [23:0] ratio;
      logic [31:0] ppm;
   } reading_type;

   localparam longint FULL_SCALE = (64'd1 << DEF_ADC_BITS) - 1;
   localparam longint MAX32 = 64'hFFFF_FFFF;
   localparam longint MAX24 = 64'hFF_FFFF;

   // 2^(2^-k) in Q2.30, k = 1..16
   localparam longint ROOT_TAB [16] = '{
      1518500250, 1276901417, 1170923762, 1121280436,
      1097253708, 1085434106, 1079572136, 1076653033,
      1075196443, 1074468888, 1074105294, 1073923544,
      1073832680, 1073787251, 1073764537, 1073753181};

   logic [19:0] load_r;
   logic [15:0] clean_ratio;
   logic [23:0] scale_a;
   logic signed [15:0] expo_b;
   logic [6:0]  cal_count;
   logic [39:0] rs_sum;
   logic [31:0] r0;
   logic        cal_done;
   reading_type expected_q[$];

   function automatic longint fdiv(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      return q;
   endfunction

   function automatic longint log2_fix(longint r);
      int p;
      longint m;
      longint frac;
      p = 23;
      frac = 0;
      while (p > 0 && r[p] == 1'b0) p--;
      m = r << (23 - p);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >>> 23;
         frac = frac << 1;
         if (m >= (64'd1 << 24)) begin
            frac = frac | 1;
            m = m >>> 1;
         end
      end
      return longint'(p - 16) * 65536 + frac;
   endfunction

   function automatic longint power_scale(longint a, longint e);
      longint n;
      longint f;
      longint acc;
      longint prod;
      longint s;
      n = fdiv(e, 65536);
      f = e - n * 65536;
      acc = 64'd1 << 30;
      for (int k = 0; k < 16; k++)
         if (f[15-k]) acc = (acc * ROOT_TAB[k]) >>> 30;
      prod = a * acc;
      s = n - 30;
      if (prod == 0) return 0;
      if (s >= 0) begin
         if (s >= 32 || prod > (MAX32 >>> s)) return MAX32;
         return prod << s;
      end
      if (-s >= 64) return 0;
      prod = prod >>> (-s);
      return prod > MAX32 ? MAX32 : prod;
   endfunction

   function automatic reading_type convert(logic [11:0] raw);
      reading_type o;
      longint rs;
      longint ratio;
      longint ppm;
      longint den;
      longint base;
      o = '{status: ST_ZERO, rs: 0, ratio: 0, ppm: 0};
      if (raw == 0) return o;
      rs = (longint'(raw) > FULL_SCALE) ? 0 :
           (longint'(load_r) * (FULL_SCALE - longint'(raw))) / longint'(raw);
      if (rs > MAX32) rs = MAX32;
      o.rs = rs[31:0];
      if (!cal_done) begin
         rs_sum = rs_sum + rs[39:0];
         cal_count = cal_count + 7'd1;
         if (cal_count >= DEF_CAL_SAMPLES) begin
            den = longint'(DEF_CAL_SAMPLES) * longint'(clean_ratio);
            base = (den == 0) ? MAX32 : (longint'(rs_sum) << 8) / den;
            r0 = (base > MAX32) ? 32'hFFFF_FFFF : base[31:0];
            cal_done = 1'b1;
            o.status = ST_DONE;
         end else begin
            o.status = ST_CAL;
         end
         return o;
      end
      ratio = (r0 == 0) ? MAX24 : (rs << 16) / longint'(r0);
      if (ratio > MAX24) ratio = MAX24;
      if (ratio == 0) begin
         if (expo_b > 0) ppm = 0;
         else if (expo_b == 0) ppm = scale_a;
         else ppm = MAX32;
      end else begin
         ppm = power_scale(longint'(scale_a),
                           fdiv(log2_fix(ratio) * longint'(expo_b), 4096));
      end
      o.status = ST_MEAS;
      o.ratio = ratio[23:0];
      o.ppm = ppm[31:0];
      return o;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      reading_type got;
      reading_type exp_r;
      if (reset) begin
         load_r <= 20'd10000;
         clean_ratio <= 16'd2534;
         scale_a <= 24'd256000;
         expo_b <= -16'sd9011;
         cal_count = 0;
         rs_sum = 0;
         r0 = 0;
         cal_done = 0;
         errors <= 0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_LOAD:  load_r <= csr_wdata[19:0];
               REG_CAR:   clean_ratio <= csr_wdata[15:0];
               REG_COEFA: scale_a <= csr_wdata[23:0];
               REG_COEFB: expo_b <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) expected_q.push_back(convert(req_tdata[11:0]));
         if (rsp_tvalid && rsp_tready) begin
            got = '{status: rsp_tuser, rs: rsp_tdata[31:0], ratio: rsp_tdata[55:32],
                    ppm: rsp_tdata[87:56]};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected transfer %h", $time, got);
               errors <= errors + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (got !== exp_r) begin
                  $display("%0t: mismatch exp st %0d rs %0d ratio %0d ppm %0d",
                           $time, exp_r.status, exp_r.rs, exp_r.ratio, exp_r.ppm);
                  $display("%0t:          got st %0d rs %0d ratio %0d ppm %0d",
                           $time, got.status, got.rs, got.ratio, got.ppm);
                  errors <= errors + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

@@ dv/gas_sensor_ppm_converter_tb.sv @@
// Testbench top for the gas sensor ppm converter: stimulus, idling phases and verdict.
`default_nettype none
module gas_sensor_ppm_converter_tb;
   import gsp_pkg::*;

   localparam int LIMIT = 4000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int          errors;
   int          pending;
   int          mode;
   int          cycles;

   gas_sensor_ppm_converter i_dut (.*);

   gas_sensor_ppm_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
   always @(negedge clock)
      case (mode)
         2: rsp_tready <= ($urandom_range(99) >= 60);
         3: rsp_tready <= ($urandom_range(99) >= 12);
         default: rsp_tready <= 1'b1;
      endcase

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("gas_sensor_ppm_converter_tb NOT OK");
         $finish;
      end
   end

   task automatic send_sample(logic [11:0] raw);
      int idle_pct;
      idle_pct = (mode == 1) ? 60 : (mode == 3) ? 12 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {4'd0, raw};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   function automatic logic [11:0] pick_raw();
      int sel;
      sel = $urandom_range(99);
      if (sel < 3) return 12'd0;
      if (sel < 6) return 12'd1;
      if (sel < 9) return 12'hFFF;
      if (sel < 12) return 12'hFFE;
      if (sel < 40) return 12'($urandom_range(4095, 1024));
      return 12'($urandom_range(4095, 1));
   endfunction

   localparam logic [11:0] EDGE_RAW [10] = '{12'd0, 12'd1, 12'hFFF, 12'hFFE, 12'd2048,
                                           12'd2, 12'h800, 12'h7FF, 12'h555, 12'hAAA};

   initial begin
      logic [15:0] bval;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mode = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      write_reg(REG_LOAD, 24'd10000);
      write_reg(REG_CAR, 24'd2534);
      // calibration run, with a zero sample and extremes mixed in
      for (int i = 0; i < 108; i++)
         send_sample(i < 10 ? EDGE_RAW[i] : pick_raw());
      for (int p = 0; p < 8; p++) begin
         drain();
         mode = p % 4;
         case (p)
            0: begin
               write_reg(REG_LOAD, 24'd10000);
               write_reg(REG_COEFA, 24'd256000);
               bval = -16'sd9011;
            end
            1: begin
               write_reg(REG_LOAD, 24'hFFFFF);
               write_reg(REG_COEFA, 24'hFFFFFF);
               bval = 16'h7FFF;
            end
            2: begin
               write_reg(REG_LOAD, 24'd1);
               write_reg(REG_COEFA, 24'd0);
               bval = 16'h8000;
            end
            3: begin
               write_reg(REG_LOAD, 24'($urandom_range(1048575, 1)));
               write_reg(REG_COEFA, 24'($urandom_range(16777215)));
               bval = 16'd0;
            end
            default: begin
               write_reg(REG_LOAD, 24'($urandom_range(1048575, 1)));
               write_reg(REG_COEFA, 24'($urandom_range(16777215)));
               bval = 16'($urandom_range(65535));
            end
         endcase
         write_reg(REG_COEFB, {8'd0, bval});
         write_reg(REG_CAR, (p % 2) ? 24'hFFFF : 24'd1);
         for (int i = 0; i < 220; i++) begin
            if (p == 5 && i % 20 == 0)
               while (pending != 0) @(negedge clock);
            send_sample((p < 3 && i < 10) ? EDGE_RAW[i] : pick_raw());
         end
      end
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (errors == 0)
         $display("gas_sensor_ppm_converter_tb OK");
      else
         $display("gas_sensor_ppm_converter_tb NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
